[src/ilns_pkg.sv]
package ilns_pkg;

  // Q.28 working format for c, x, 1-x and the logarithm
  localparam int XF    = 28;
  localparam int XW    = XF;          // x in [0, 1)
  localparam int UW    = XF + 1;      // 1-x in (0, 1]
  localparam int SW    = 5;           // normalize shift, 0..28
  localparam int L2W   = SW + XF;     // -log2 and -ln
  localparam int CW    = 33;          // c in [0, 16]
  localparam int DW    = 31;          // side width
  localparam int NW    = 62;          // |a|*|psi| and delta^2
  localparam int RW_C  = NW + 3;      // remainder of the c divider
  localparam int QW_C  = 32;          // quotient bits of c
  localparam int NPW   = CW + UW;     // |dx numerator| * (1-x)
  localparam int QW_N  = 31;          // quotient bits of the Newton step
  localparam int XSW   = QW_N + 2;    // signed x update

  localparam logic [XW-1:0]   X_HALF   = 28'd134217728;
  localparam logic [XW-1:0]   X_MAX    = 28'd268167021;
  localparam logic [XF-1:0]   LN2_Q    = 28'd186065279;
  localparam logic [CW-1:0]   C_MAX    = 33'h1_0000_0000;
  localparam logic [QW_N-1:0] STEP_CAP = 31'h4000_0000;

  typedef struct packed {
    logic signed [31:0] coef_a;
    logic signed [31:0] flux_value;
    logic [30:0]        delta_plus;
    logic [30:0]        delta_minus;
  } ilns_in_t;

  typedef struct packed {
    logic signed [31:0] limit_plus;
    logic signed [31:0] limit_minus;
    logic signed [31:0] full_width;
    logic               bad_delta;
  } ilns_out_t;

  typedef struct packed {
    logic          bad;
    logic [DW-1:0] delta;
  } ilns_side_t;

endpackage

[src/ilns_div_cell.sv]
module ilns_div_cell #(
  parameter int RW = 8,
  parameter int QW = 4,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [RW-1:0] in_rem,
  input  logic [RW-1:0] in_dvs,
  input  logic [QW-1:0] in_quo,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [RW-1:0] out_rem,
  output logic [RW-1:0] out_dvs,
  output logic [QW-1:0] out_quo,
  output logic [PW-1:0] out_pay
);

  logic          valid_r;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [RW-1:0] dvs_r;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [PW-1:0] pay_r;
  logic          ge;
  logic [RW-1:0] diff;

  // one restoring step: divisor stays put, remainder shifts up
  always_comb begin
    ge      = (in_rem >= in_dvs);
    diff    = ge ? (in_rem - in_dvs) : in_rem;
    rem_nxt = {diff[RW-2:0], 1'b0};
    quo_nxt = {in_quo[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      dvs_r <= in_dvs;
      quo_r <= quo_nxt;
      pay_r <= in_pay;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_dvs   = dvs_r;
  assign out_quo   = quo_r;
  assign out_pay   = pay_r;

endmodule

[src/ilns_sq_cell.sv]
module ilns_sq_cell #(
  parameter int PW = 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [ilns_pkg::UW-1:0] in_mant,
  input  logic [ilns_pkg::XW-1:0] in_frac,
  input  logic [PW-1:0]           in_pay,
  output logic                    out_valid,
  output logic [ilns_pkg::UW-1:0] out_mant,
  output logic [ilns_pkg::XW-1:0] out_frac,
  output logic [PW-1:0]           out_pay
);
  import ilns_pkg::*;

  logic            valid_r;
  logic [UW-1:0]   mant_r, mant_nxt;
  logic [XW-1:0]   frac_r, frac_nxt;
  logic [PW-1:0]   pay_r;
  logic [2*UW-1:0] sq;
  logic [UW:0]     m2;

  // mantissa in [1,2): square, renormalize, one log2 bit per cell
  always_comb begin
    sq       = {{UW{1'b0}}, in_mant} * {{UW{1'b0}}, in_mant};
    m2       = sq[2*UW-1:XF];
    mant_nxt = m2[UW] ? m2[UW:1] : m2[UW-1:0];
    frac_nxt = {in_frac[XW-2:0], m2[UW]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mant_r <= mant_nxt;
      frac_r <= frac_nxt;
      pay_r  <= in_pay;
    end
  end

  assign out_valid = valid_r;
  assign out_mant  = mant_r;
  assign out_frac  = frac_r;
  assign out_pay   = pay_r;

endmodule

[src/ilns_newton_step.sv]
module ilns_newton_step (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [ilns_pkg::CW-1:0] in_c,
  input  logic [ilns_pkg::XW-1:0] in_x,
  input  ilns_pkg::ilns_side_t    in_side,
  output logic                    out_valid,
  output logic [ilns_pkg::CW-1:0] out_c,
  output logic [ilns_pkg::XW-1:0] out_x,
  output ilns_pkg::ilns_side_t    out_side
);
  import ilns_pkg::*;

  typedef struct packed {
    logic [CW-1:0] c;
    logic [XW-1:0] x;
    logic [UW-1:0] u;
    logic [SW-1:0] sh;
    ilns_side_t    side;
  } log_pay_t;

  typedef struct packed {
    logic [CW-1:0] c;
    logic [XW-1:0] x;
    logic          neg_d;
    logic          sat;
    ilns_side_t    side;
  } div_pay_t;

  localparam int NSQ = XF;
  localparam int NDV = QW_N;
  localparam int LPW = $bits(log_pay_t);
  localparam int DPW = $bits(div_pay_t);

  // ---- normalize 1-x ----
  logic [UW-1:0] u_a;
  logic [SW-1:0] lz_a;
  log_pay_t      norm_pay_nxt;
  logic          norm_valid_r;
  logic [UW-1:0] norm_mant_r;
  log_pay_t      norm_pay_r;

  always_comb begin
    u_a  = {1'b1, {XF{1'b0}}} - {1'b0, in_x};
    lz_a = '0;
    for (int i = 0; i < UW; i++) begin
      if (u_a[i]) lz_a = SW'(UW - 1 - i);
    end
    norm_pay_nxt.c    = in_c;
    norm_pay_nxt.x    = in_x;
    norm_pay_nxt.u    = u_a;
    norm_pay_nxt.sh   = lz_a;
    norm_pay_nxt.side = in_side;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_valid_r <= 1'b0;
    end else if (en) begin
      norm_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      norm_mant_r <= u_a << lz_a;
      norm_pay_r  <= norm_pay_nxt;
    end
  end

  // ---- log2 by repeated squaring ----
  logic           sq_valid [NSQ+1];
  logic [UW-1:0]  sq_mant  [NSQ+1];
  logic [XW-1:0]  sq_frac  [NSQ+1];
  logic [LPW-1:0] sq_pay   [NSQ+1];

  assign sq_valid[0] = norm_valid_r;
  assign sq_mant[0]  = norm_mant_r;
  assign sq_frac[0]  = '0;
  assign sq_pay[0]   = norm_pay_r;

  for (genvar i = 0; i < NSQ; i++) begin : g_sq
    ilns_sq_cell #(.PW(LPW)) u_sq (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (sq_valid[i]),
      .in_mant   (sq_mant[i]),
      .in_frac   (sq_frac[i]),
      .in_pay    (sq_pay[i]),
      .out_valid (sq_valid[i+1]),
      .out_mant  (sq_mant[i+1]),
      .out_frac  (sq_frac[i+1]),
      .out_pay   (sq_pay[i+1])
    );
  end

  // ---- -ln(1-x) = -log2 * ln2, rounded ----
  log_pay_t             lp_c;
  logic [L2W-1:0]       l2_c;
  logic [L2W+XF-1:0]    lnp_c;
  logic                 ln_valid_r;
  logic [L2W-1:0]       ln_r;
  log_pay_t             ln_pay_r;

  always_comb begin
    lp_c  = log_pay_t'(sq_pay[NSQ]);
    l2_c  = {lp_c.sh, {XF{1'b0}}} - {{SW{1'b0}}, sq_frac[NSQ]};
    lnp_c = {{XF{1'b0}}, l2_c} * {{L2W{1'b0}}, LN2_Q}
          + {{L2W{1'b0}}, 1'b1, {(XF-1){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ln_valid_r <= 1'b0;
    end else if (en) begin
      ln_valid_r <= sq_valid[NSQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ln_r     <= lnp_c[L2W+XF-1:XF];
      ln_pay_r <= lp_c;
    end
  end

  // ---- residual c - g(x) = c + x + ln(1-x), magnitude and sign ----
  logic signed [CW:0] dd_c;
  logic [CW:0]        dabs_c;
  logic               res_valid_r;
  logic [CW-1:0]      mag_r;
  logic               res_neg_r;
  log_pay_t           res_pay_r;

  always_comb begin
    dd_c = signed'({1'b0, ln_pay_r.c})
         + signed'({{(CW+1-XW){1'b0}}, ln_pay_r.x})
         - signed'({{(CW+1-L2W){1'b0}}, ln_r});
    dabs_c = dd_c[CW] ? (-dd_c) : dd_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (en) begin
      res_valid_r <= ln_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r     <= dabs_c[CW-1:0];
      res_neg_r <= dd_c[CW];
      res_pay_r <= ln_pay_r;
    end
  end

  // ---- step numerator |r| * (1-x) ----
  logic             num_valid_r;
  logic [NPW-1:0]   num_r;
  logic             num_neg_r;
  log_pay_t         num_pay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_valid_r <= 1'b0;
    end else if (en) begin
      num_valid_r <= res_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r     <= {{UW{1'b0}}, mag_r} * {{CW{1'b0}}, res_pay_r.u};
      num_neg_r <= res_neg_r;
      num_pay_r <= res_pay_r;
    end
  end

  // ---- divide by x; a quotient of 2^31 or more is capped outright ----
  div_pay_t       dv_pay0;
  logic           dv_valid [NDV+1];
  logic [NPW-1:0] dv_rem   [NDV+1];
  logic [NPW-1:0] dv_dvs   [NDV+1];
  logic [QW_N-1:0] dv_quo  [NDV+1];
  logic [DPW-1:0] dv_pay   [NDV+1];

  always_comb begin
    dv_pay0.c     = num_pay_r.c;
    dv_pay0.x     = num_pay_r.x;
    dv_pay0.neg_d = num_neg_r;
    dv_pay0.sat   = num_r >= {{(NPW-XW-QW_N){1'b0}}, num_pay_r.x, {QW_N{1'b0}}};
    dv_pay0.side  = num_pay_r.side;
  end

  assign dv_valid[0] = num_valid_r;
  assign dv_rem[0]   = num_r;
  assign dv_dvs[0]   = {{(NPW-XW-QW_N+1){1'b0}}, num_pay_r.x, {(QW_N-1){1'b0}}};
  assign dv_quo[0]   = '0;
  assign dv_pay[0]   = dv_pay0;

  for (genvar i = 0; i < NDV; i++) begin : g_div
    ilns_div_cell #(.RW(NPW), .QW(QW_N), .PW(DPW)) u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (dv_valid[i]),
      .in_rem    (dv_rem[i]),
      .in_dvs    (dv_dvs[i]),
      .in_quo    (dv_quo[i]),
      .in_pay    (dv_pay[i]),
      .out_valid (dv_valid[i+1]),
      .out_rem   (dv_rem[i+1]),
      .out_dvs   (dv_dvs[i+1]),
      .out_quo   (dv_quo[i+1]),
      .out_pay   (dv_pay[i+1])
    );
  end

  // ---- update and clamp x ----
  div_pay_t            up_c;
  logic [QW_N-1:0]     qc_c;
  logic signed [XSW-1:0] xs_c;
  logic [XW-1:0]       x_nxt;
  logic                up_valid_r;
  logic [CW-1:0]       up_c_r;
  logic [XW-1:0]       up_x_r;
  ilns_side_t          up_side_r;

  always_comb begin
    up_c = div_pay_t'(dv_pay[NDV]);
    qc_c = (up_c.sat || (dv_quo[NDV] > STEP_CAP)) ? STEP_CAP : dv_quo[NDV];
    if (up_c.neg_d) begin
      xs_c = signed'({{(XSW-XW){1'b0}}, up_c.x}) - signed'({{(XSW-QW_N){1'b0}}, qc_c});
    end else begin
      xs_c = signed'({{(XSW-XW){1'b0}}, up_c.x}) + signed'({{(XSW-QW_N){1'b0}}, qc_c});
    end
    // x stuck at zero stays there
    if (up_c.x == '0) begin
      x_nxt = up_c.x;
    end else if (xs_c[XSW-1]) begin
      x_nxt = '0;
    end else if (|xs_c[XSW-2:XW]) begin
      x_nxt = X_MAX;
    end else begin
      x_nxt = xs_c[XW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_valid_r <= 1'b0;
    end else if (en) begin
      up_valid_r <= dv_valid[NDV];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      up_c_r    <= up_c.c;
      up_x_r    <= x_nxt;
      up_side_r <= up_c.side;
    end
  end

  assign out_valid = up_valid_r;
  assign out_c     = up_c_r;
  assign out_x     = up_x_r;
  assign out_side  = up_side_r;

endmodule

[src/island_limits_newton_solver_top.sv]
// Island limit solver.
// Input channel in_valid/in_stall/in_data carries coef_a, flux_value,
// delta_plus and delta_minus; output channel out_valid/out_stall/out_data
// carries limit_plus, limit_minus, full_width and bad_delta. A transfer
// happens on a clock edge with valid high and stall low.
// One item is taken per cycle while in_stall is low, and one result comes out per item, in order.
// From input transfer to out_valid the path holds 1 front multiply stage,
// 32 divider cells for c, 64 cells per Newton step (normalize, 28 squaring
// cells for the log, 3 arithmetic cells, 31 divider cells, update), 1 output
// multiply and the output register. Every cell is fully pipelined, so
// throughput is one item per clock while in_stall is low.
// A skid register behind the output register absorbs the one result in
// flight when the receiver stalls; in_stall rises only while the skid
// register is full, and the whole cell chain holds until it drains.
// Synchronous active-low reset clears all valid flags; the block is ready
// for a transfer on the first cycle after reset.
module island_limits_newton_solver_top #(
  parameter int NUM_STEPS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ilns_pkg::ilns_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ilns_pkg::ilns_out_t out_data
);
  import ilns_pkg::*;

  typedef struct packed {
    logic       sat;
    ilns_side_t side;
  } cdiv_pay_t;

  localparam int CPW = $bits(cdiv_pay_t);

  logic out_v_r, out_v_nxt;
  logic skid_v_r, skid_v_nxt;
  logic adv;
  assign adv = !skid_v_r;

  // ---- front: |psi|, product and squared widths ----
  logic [31:0]     pmag;
  logic [NW:0]     nprod;
  logic [2*DW-1:0] d2p, d2m;
  logic            bad_in;
  logic            fr_valid_r;
  logic [NW-1:0]   fr_n_r;
  logic [NW-1:0]   fr_d2_r   [2];
  ilns_side_t      fr_side_r [2];

  always_comb begin
    pmag   = in_data.flux_value[31] ? (~in_data.flux_value + 32'd1) : in_data.flux_value;
    nprod  = {32'b0, in_data.coef_a[30:0]} * {31'b0, pmag};
    d2p    = {{DW{1'b0}}, in_data.delta_plus} * {{DW{1'b0}}, in_data.delta_plus};
    d2m    = {{DW{1'b0}}, in_data.delta_minus} * {{DW{1'b0}}, in_data.delta_minus};
    bad_in = (in_data.delta_plus == '0) || (in_data.delta_minus == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (adv) begin
      fr_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // a negative coefficient has no root: c = 0
      fr_n_r             <= in_data.coef_a[31] ? '0 : nprod[NW-1:0];
      fr_d2_r[0]         <= d2p;
      fr_d2_r[1]         <= d2m;
      fr_side_r[0].bad   <= bad_in;
      fr_side_r[0].delta <= in_data.delta_plus;
      fr_side_r[1].bad   <= bad_in;
      fr_side_r[1].delta <= in_data.delta_minus;
    end
  end

  // ---- per side: c divider, Newton chain, scale by delta ----
  logic          o_valid_r [2];
  logic [DW-1:0] o_lim_r   [2];
  ilns_side_t    o_side_r  [2];

  for (genvar sd = 0; sd < 2; sd++) begin : g_side
    cdiv_pay_t       cd_pay0;
    cdiv_pay_t       cd_last;
    logic            cd_valid [QW_C+1];
    logic [RW_C-1:0] cd_rem   [QW_C+1];
    logic [RW_C-1:0] cd_dvs   [QW_C+1];
    logic [QW_C-1:0] cd_quo   [QW_C+1];
    logic [CPW-1:0]  cd_pay   [QW_C+1];
    logic            nt_valid [NUM_STEPS+1];
    logic [CW-1:0]   nt_c     [NUM_STEPS+1];
    logic [XW-1:0]   nt_x     [NUM_STEPS+1];
    ilns_side_t      nt_side  [NUM_STEPS+1];
    logic [DW+XW-1:0] scl;

    always_comb begin
      cd_pay0.sat  = {3'b0, fr_n_r} >= {fr_d2_r[sd], 3'b0};
      cd_pay0.side = fr_side_r[sd];
    end

    assign cd_valid[0] = fr_valid_r;
    assign cd_rem[0]   = {3'b0, fr_n_r};
    assign cd_dvs[0]   = {1'b0, fr_d2_r[sd], 2'b0};
    assign cd_quo[0]   = '0;
    assign cd_pay[0]   = cd_pay0;

    for (genvar i = 0; i < QW_C; i++) begin : g_cdiv
      ilns_div_cell #(.RW(RW_C), .QW(QW_C), .PW(CPW)) u_cdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (cd_valid[i]),
        .in_rem    (cd_rem[i]),
        .in_dvs    (cd_dvs[i]),
        .in_quo    (cd_quo[i]),
        .in_pay    (cd_pay[i]),
        .out_valid (cd_valid[i+1]),
        .out_rem   (cd_rem[i+1]),
        .out_dvs   (cd_dvs[i+1]),
        .out_quo   (cd_quo[i+1]),
        .out_pay   (cd_pay[i+1])
      );
    end

    assign cd_last     = cdiv_pay_t'(cd_pay[QW_C]);
    assign nt_valid[0] = cd_valid[QW_C];
    assign nt_c[0]     = cd_last.sat ? C_MAX : {1'b0, cd_quo[QW_C]};
    assign nt_x[0]     = X_HALF;
    assign nt_side[0]  = cd_last.side;

    for (genvar s = 0; s < NUM_STEPS; s++) begin : g_step
      ilns_newton_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (nt_valid[s]),
        .in_c      (nt_c[s]),
        .in_x      (nt_x[s]),
        .in_side   (nt_side[s]),
        .out_valid (nt_valid[s+1]),
        .out_c     (nt_c[s+1]),
        .out_x     (nt_x[s+1]),
        .out_side  (nt_side[s+1])
      );
    end

    // round half up of delta * root
    assign scl = {{XW{1'b0}}, nt_side[NUM_STEPS].delta} * {{DW{1'b0}}, nt_x[NUM_STEPS]}
               + {{DW{1'b0}}, 1'b1, {(XF-1){1'b0}}};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        o_valid_r[sd] <= 1'b0;
      end else if (adv) begin
        o_valid_r[sd] <= nt_valid[NUM_STEPS];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        o_lim_r[sd]  <= scl[DW+XW-1:XF];
        o_side_r[sd] <= nt_side[NUM_STEPS];
      end
    end
  end

  // ---- combine sides ----
  ilns_out_t res;
  logic [32:0] fw_sum;
  logic        push;

  always_comb begin
    fw_sum = {2'b0, o_lim_r[0]} + {2'b0, o_lim_r[1]};
    res.bad_delta = o_side_r[0].bad | o_side_r[1].bad;
    if (res.bad_delta) begin
      res.limit_plus  = '0;
      res.limit_minus = '0;
      res.full_width  = '0;
    end else begin
      res.limit_plus  = {1'b0, o_lim_r[0]};
      res.limit_minus = 32'd0 - {1'b0, o_lim_r[1]};
      res.full_width  = (|fw_sum[32:31]) ? 32'h7FFF_FFFF : fw_sum[31:0];
    end
  end

  assign push = adv && o_valid_r[0] && o_valid_r[1];

  // ---- output register and skid ----
  ilns_out_t out_data_r;
  ilns_out_t skid_data_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    if (!out_v_r || !out_stall) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = push;
      end
    end else if (push) begin
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || !out_stall) begin
      out_data_r <= skid_v_r ? skid_data_r : res;
    end
    if (out_v_r && out_stall && push) begin
      skid_data_r <= res;
    end
  end

  assign in_stall  = skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  // ---- checks ----
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds a result while the output register is empty");

  a_held_goes_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_stall && push) |=> skid_v_r)
    else $error("result arriving behind a stalled output was dropped");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !out_v_r) |=> out_v_r)
    else $error("result from the chain did not reach the output register");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_data_r.bad_delta) |->
      (out_data_r.limit_plus == 0 && out_data_r.limit_minus == 0 &&
       out_data_r.full_width == 0))
    else $error("zero width item produced nonzero limits");

endmodule
